>>> rtl/wmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_pkg
// Shared types and constants of the weighted mask blur.
// ----------------------------------------------------------------------------
package wmb_pkg;

  localparam int unsigned DefMaxWidth   = 1024;
  localparam int unsigned DefMaxHeight  = 1024;
  localparam int unsigned DefMaxMask    = 5;
  localparam int unsigned DefStoreDepth = 8192;

  localparam int unsigned NumWeights = 25;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned PixW       = 32;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaskSize    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWeightsA    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWeightsB    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWeightsC    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWeightsD    = 3'd6;

  localparam logic CmdPixel = 1'b0;

  typedef struct packed {
    logic            command;
    logic [PixW-1:0] in_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            out_last;
    logic            zero_total;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic tap_init;
    logic tap_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic eligible;
    logic tap_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/wmb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wmb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8192,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/wmb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_ctrl
// Sequencer: takes a request, checks whether a result is due, walks the mask
// taps, runs the divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module wmb_ctrl
  import wmb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StTaps,
    StFlush,
    StDivInit,
    StDiv,
    StOut
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = StCheck;
      end
      StCheck: begin
        if (status_i.eligible) begin
          cmd_o.tap_init = 1'b1;
          state_d        = StTaps;
        end else begin
          state_d = StIdle;
        end
      end
      StTaps: begin
        cmd_o.tap_step = 1'b1;
        if (status_i.tap_last) state_d = StFlush;
      end
      StFlush: begin
        state_d = StDivInit;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/wmb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_dp
// Datapath: configuration, line store, frame counters, tap accumulation,
// shared restoring divider and output register.
// ----------------------------------------------------------------------------
module wmb_dp
  import wmb_pkg::*;
#(
  parameter int unsigned MaxWidth   = DefMaxWidth,
  parameter int unsigned MaxHeight  = DefMaxHeight,
  parameter int unsigned MaxMask    = DefMaxMask,
  parameter int unsigned StoreDepth = DefStoreDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire dp_cmd_t             cmd_i,
  output dp_status_t               status_o
);

  localparam int unsigned WdW   = $clog2(MaxWidth + 1);
  localparam int unsigned HdW   = $clog2(MaxHeight + 1);
  localparam int unsigned CntW  = $clog2(MaxWidth * MaxHeight + 1);
  localparam int unsigned NeedW = CntW + 2;
  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned ProdW = (WdW + HdW + 1 > AddrW) ? WdW + HdW + 1 : AddrW;
  localparam int unsigned RcvW  = (CntW > AddrW) ? CntW : AddrW;
  localparam int unsigned KW    = $clog2(NumWeights + 1);
  localparam int unsigned TotW  = 8 + KW;
  localparam int unsigned SumW  = 16 + KW;
  localparam int unsigned QW    = 8;
  localparam int unsigned BitW  = $clog2(QW);

  // Configuration registers.
  logic [10:0] width_q, height_q;
  logic [2:0]  mask_q;
  logic [7:0]  wt_q [NumWeights];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      mask_q   <= 3'd3;
      for (int i = 0; i < NumWeights; i++) wt_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth:  width_q  <= cfg_data_i[10:0];
        RegImageHeight: height_q <= cfg_data_i[10:0];
        RegMaskSize:    mask_q   <= cfg_data_i[2:0];
        RegWeightsA:    for (int i = 0; i < 8; i++) wt_q[i]      <= cfg_data_i[8*i +: 8];
        RegWeightsB:    for (int i = 0; i < 8; i++) wt_q[8 + i]  <= cfg_data_i[8*i +: 8];
        RegWeightsC:    for (int i = 0; i < 8; i++) wt_q[16 + i] <= cfg_data_i[8*i +: 8];
        RegWeightsD:    wt_q[24] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic geo_wr;
  assign geo_wr = cfg_we_i && (cfg_idx_i == RegImageWidth || cfg_idx_i == RegImageHeight ||
                               cfg_idx_i == RegMaskSize);

  // Effective geometry.
  logic [WdW-1:0]  w_eff;
  logic [HdW-1:0]  h_eff;
  logic [2:0]      m0, m1, m_eff;
  logic [1:0]      half;
  logic [CntW-1:0] total;
  logic [NeedW-1:0] lag, need_raw, need;

  always_comb begin
    if (width_q == '0) w_eff = WdW'(1);
    else if (32'(width_q) > 32'(MaxWidth)) w_eff = WdW'(MaxWidth);
    else w_eff = WdW'(width_q);
    if (height_q == '0) h_eff = HdW'(1);
    else if (32'(height_q) > 32'(MaxHeight)) h_eff = HdW'(MaxHeight);
    else h_eff = HdW'(height_q);
    m0 = (mask_q == '0) ? 3'd1 : mask_q;
    m1 = (32'(m0) > 32'(MaxMask)) ? 3'(MaxMask) : m0;
    m_eff = m1[0] ? m1 : m1 - 3'd1;
    if (m_eff == '0) m_eff = 3'd1;
    half = m_eff[2:1];
  end

  assign total = CntW'(w_eff * h_eff);
  assign lag   = NeedW'(half * w_eff) + NeedW'(half);

  // Frame counters and position of the next result.
  logic [CntW-1:0] rcv_q, emit_q;
  logic [HdW-1:0]  erow_q;
  logic [WdW-1:0]  ecol_q;
  logic            store_px;
  logic            emit_done;

  assign need_raw = NeedW'(emit_q) + lag + NeedW'(1);
  assign need     = (need_raw > NeedW'(total)) ? NeedW'(total) : need_raw;
  assign store_px = cmd_i.accept && (in_data_i.command == CmdPixel) && (rcv_q < total);
  assign emit_done = (emit_q + CntW'(1)) == total;

  assign status_o.eligible = (emit_q < total) && (NeedW'(rcv_q) >= need);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q  <= '0;
      emit_q <= '0;
      erow_q <= '0;
      ecol_q <= '0;
    end else if (geo_wr) begin
      rcv_q  <= '0;
      emit_q <= '0;
      erow_q <= '0;
      ecol_q <= '0;
    end else begin
      if (store_px) rcv_q <= rcv_q + CntW'(1);
      if (cmd_i.load_out) begin
        if (emit_done) begin
          rcv_q  <= '0;
          emit_q <= '0;
          erow_q <= '0;
          ecol_q <= '0;
        end else begin
          emit_q <= emit_q + CntW'(1);
          if (ecol_q == w_eff - WdW'(1)) begin
            ecol_q <= '0;
            erow_q <= erow_q + HdW'(1);
          end else begin
            ecol_q <= ecol_q + WdW'(1);
          end
        end
      end
    end
  end

  // Tap walk: one store read per tap inside the frame.
  logic [2:0]     mr_q, mc_q;
  logic [KW-1:0]  k_q;
  logic [HdW:0]   rr;
  logic [WdW:0]   qq;
  logic [HdW-1:0] r_pos;
  logic [WdW-1:0] q_pos;
  logic           tap_in;
  logic [ProdW-1:0] tap_lin;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [PixW-1:0]  rd_data;
  logic             use_q, center_q;
  logic [7:0]       twt_q;

  assign rr    = {1'b0, erow_q} + (HdW + 1)'(mr_q);
  assign qq    = {1'b0, ecol_q} + (WdW + 1)'(mc_q);
  assign r_pos = HdW'(rr - (HdW + 1)'(half));
  assign q_pos = WdW'(qq - (WdW + 1)'(half));
  assign tap_in = (rr >= (HdW + 1)'(half)) && (qq >= (WdW + 1)'(half)) &&
                  ((rr - (HdW + 1)'(half)) < (HdW + 1)'(h_eff)) &&
                  ((qq - (WdW + 1)'(half)) < (WdW + 1)'(w_eff)) &&
                  (32'(k_q) < 32'(NumWeights));
  assign tap_lin = ProdW'(r_pos * w_eff) + ProdW'(q_pos);
  assign rd_addr = AddrW'(tap_lin);
  assign wr_addr = AddrW'(RcvW'(rcv_q));
  assign status_o.tap_last = (mr_q == m_eff - 3'd1) && (mc_q == m_eff - 3'd1);

  wmb_ram #(
    .Width(PixW),
    .Depth(StoreDepth)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (store_px),
    .waddr_i(wr_addr),
    .wdata_i(in_data_i.in_pixel),
    .re_i   (cmd_i.tap_step && tap_in),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  logic [SumW-1:0] sr_q, sg_q, sb_q;
  logic [TotW-1:0] tot_q;
  logic [7:0]      alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mr_q     <= '0;
      mc_q     <= '0;
      k_q      <= '0;
      use_q    <= 1'b0;
      center_q <= 1'b0;
    end else begin
      use_q    <= cmd_i.tap_step && tap_in;
      center_q <= cmd_i.tap_step && (mr_q == 3'(half)) && (mc_q == 3'(half));
      if (cmd_i.tap_init) begin
        mr_q <= '0;
        mc_q <= '0;
        k_q  <= '0;
      end else if (cmd_i.tap_step) begin
        k_q <= k_q + KW'(1);
        if (mc_q == m_eff - 3'd1) begin
          mc_q <= '0;
          mr_q <= mr_q + 3'd1;
        end else begin
          mc_q <= mc_q + 3'd1;
        end
      end
    end
  end

  // Weight of the tap whose read data arrives in the next cycle; weighted sums and centre alpha.
  always_ff @(posedge clk_i) begin
    twt_q <= wt_q[k_q];
    if (cmd_i.tap_init) begin
      sr_q  <= '0;
      sg_q  <= '0;
      sb_q  <= '0;
      tot_q <= '0;
    end else if (use_q) begin
      sr_q  <= sr_q + SumW'(rd_data[23:16] * twt_q);
      sg_q  <= sg_q + SumW'(rd_data[15:8] * twt_q);
      sb_q  <= sb_q + SumW'(rd_data[7:0] * twt_q);
      tot_q <= tot_q + TotW'(twt_q);
    end
    if (center_q) alpha_q <= rd_data[31:24];
  end

  // Restoring divider, one quotient bit per cycle for all three channels.
  // A weighted average never exceeds 255, so eight bits are enough.
  logic [SumW-1:0] remr_q, remg_q, remb_q, trial;
  logic [QW-1:0]   qr_q, qg_q, qb_q;
  logic [BitW-1:0] bit_q;

  assign trial = SumW'(tot_q) << bit_q;
  assign status_o.div_last = (bit_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      remr_q <= sr_q;
      remg_q <= sg_q;
      remb_q <= sb_q;
      qr_q   <= '0;
      qg_q   <= '0;
      qb_q   <= '0;
      bit_q  <= BitW'(QW - 1);
    end else if (cmd_i.div_step) begin
      if (remr_q >= trial) begin
        remr_q      <= remr_q - trial;
        qr_q[bit_q] <= 1'b1;
      end
      if (remg_q >= trial) begin
        remg_q      <= remg_q - trial;
        qg_q[bit_q] <= 1'b1;
      end
      if (remb_q >= trial) begin
        remb_q      <= remb_q - trial;
        qb_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - BitW'(1);
    end
  end

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;
  logic      zero_tot;

  assign zero_tot          = (tot_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_pixel  <= zero_tot ? {alpha_q, 24'd0} : {alpha_q, qr_q, qg_q, qb_q};
      out_q.out_last   <= emit_done;
      out_q.zero_total <= zero_tot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> rtl/weighted_mask_blur.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_mask_blur
// Streaming weighted blur over an odd square mask with border renormalization.
//
//   Channel  Handshake                Payload
//   input    in_valid_i / in_stall_o   in_data_i  (command, in_pixel)
//   output   out_valid_o / out_stall_i out_data_o (out_pixel, out_last, zero_total)
//   config   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A request that yields no result goes back to idle after its check; a request
// that yields one walks the m*m taps for an effective mask width m (one line
// store read per tap inside the frame), then eight divider steps. The output
// register lets the next request in while a result waits. Reset clears control
// state and restores the register defaults; the line store is not cleared, and
// a stalled output holds the block in its final step until the register frees.
// ----------------------------------------------------------------------------
module weighted_mask_blur
  import wmb_pkg::*;
#(
  parameter int unsigned MaxWidth   = DefMaxWidth,
  parameter int unsigned MaxHeight  = DefMaxHeight,
  parameter int unsigned MaxMask    = DefMaxMask,
  parameter int unsigned StoreDepth = DefStoreDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wmb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wmb_dp #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .MaxMask   (MaxMask),
    .StoreDepth(StoreDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
`default_nettype wire

>>> sim/weighted_mask_blur_test.sv
// ----------------------------------------------------------------------------
// weighted_mask_blur_test
// Self-checking bench for the weighted mask blur. A scoreboard class predicts
// every result from the accepted requests and the register writes, and checks
// each accepted result in order. Directed frames cover the extreme pixels,
// geometry clamps and zero weights. Random frames with random masks follow.
// ----------------------------------------------------------------------------
module weighted_mask_blur_test;
  import wmb_pkg::*;

  localparam logic CmdDrain = ~CmdPixel;
  localparam int unsigned StoreSlots = DefStoreDepth;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned WatchdogLimit = 5000;

  class blur_scoreboard;
    int unsigned width_reg, height_reg, mask_reg;
    byte unsigned weight[NumWeights];
    logic [PixW-1:0] pix_store[StoreSlots];
    int unsigned recv_cnt, emit_cnt;
    out_item_t owed[$];
    int errors;

    function new();
      width_reg = 1024;
      height_reg = 1024;
      mask_reg = 3;
      foreach (weight[i]) weight[i] = 0;
      recv_cnt = 0;
      emit_cnt = 0;
      errors = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      return (width_reg > DefMaxWidth) ? DefMaxWidth : width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      return (height_reg > DefMaxHeight) ? DefMaxHeight : height_reg;
    endfunction

    function int unsigned eff_mask();
      int unsigned m;
      m = (mask_reg == 0) ? 1 : mask_reg;
      if (m > DefMaxMask) m = DefMaxMask;
      if (m % 2 == 0) m = m - 1;
      return m;
    endfunction

    function int unsigned frame_total();
      return eff_width() * eff_height();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegImageWidth: begin
          width_reg = d[10:0];
          recv_cnt = 0;
          emit_cnt = 0;
        end
        RegImageHeight: begin
          height_reg = d[10:0];
          recv_cnt = 0;
          emit_cnt = 0;
        end
        RegMaskSize: begin
          mask_reg = d[2:0];
          recv_cnt = 0;
          emit_cnt = 0;
        end
        RegWeightsA: for (int i = 0; i < 8; i++) weight[i] = d[8*i +: 8];
        RegWeightsB: for (int i = 0; i < 8; i++) weight[8+i] = d[8*i +: 8];
        RegWeightsC: for (int i = 0; i < 8; i++) weight[16+i] = d[8*i +: 8];
        RegWeightsD: weight[24] = d[7:0];
        default: ;
      endcase
    endfunction

    // Blurred value of raster position c over the neighbors inside the frame.
    function out_item_t blur_at(int unsigned c);
      int w, h, m, half, row, col, r, q;
      int unsigned sr, sg, sb, tot, k;
      logic [PixW-1:0] px;
      out_item_t res;
      w = eff_width();
      h = eff_height();
      m = eff_mask();
      half = m / 2;
      row = c / w;
      col = c % w;
      sr = 0; sg = 0; sb = 0; tot = 0;
      for (int mr = 0; mr < m; mr++) begin
        for (int mc = 0; mc < m; mc++) begin
          r = row + mr - half;
          q = col + mc - half;
          if (r >= 0 && q >= 0 && r < h && q < w) begin
            k = mr * m + mc;
            px = pix_store[(r * w + q) % StoreSlots];
            sr += px[23:16] * weight[k];
            sg += px[15:8] * weight[k];
            sb += px[7:0] * weight[k];
            tot += weight[k];
          end
        end
      end
      res.out_pixel[31:24] = pix_store[c % StoreSlots][31:24];
      res.out_pixel[23:0] = '0;
      if (tot != 0) begin
        res.out_pixel[23:16] = 8'(sr / tot);
        res.out_pixel[15:8] = 8'(sg / tot);
        res.out_pixel[7:0] = 8'(sb / tot);
      end
      res.zero_total = (tot == 0);
      res.out_last = 1'b0;
      return res;
    endfunction

    function void note_input(in_item_t it);
      int unsigned total, lag, need;
      out_item_t res;
      total = frame_total();
      lag = (eff_mask() / 2) * eff_width() + eff_mask() / 2;
      if (it.command == CmdPixel && recv_cnt < total) begin
        pix_store[recv_cnt % StoreSlots] = it.in_pixel;
        recv_cnt++;
      end
      if (emit_cnt >= total) return;
      need = emit_cnt + lag + 1;
      if (need > total) need = total;
      if (recv_cnt < need) return;
      res = blur_at(emit_cnt);
      res.out_last = (emit_cnt + 1 == total);
      owed.push_back(res);
      emit_cnt++;
      if (emit_cnt == total) begin
        emit_cnt = 0;
        recv_cnt = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (got.out_pixel !== exp_res.out_pixel) begin
        $display("%0t: out_pixel expected %h actual %h", $time, exp_res.out_pixel,
                 got.out_pixel);
        errors++;
      end
      if (got.out_last !== exp_res.out_last) begin
        $display("%0t: out_last expected %b actual %b", $time, exp_res.out_last,
                 got.out_last);
        errors++;
      end
      if (got.zero_total !== exp_res.zero_total) begin
        $display("%0t: zero_total expected %b actual %b", $time, exp_res.zero_total,
                 got.zero_total);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_item_t out_data;

  blur_scoreboard sb = new();
  int unsigned in_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned n_reqs = 0;
  int unsigned quiet_cycles = 0;

  weighted_mask_blur uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("** weighted_mask_blur: FAILED **");
      $finish;
    end
  end

  task automatic send_req(logic cmd, logic [PixW-1:0] px);
    in_item_t it;
    it.command = cmd;
    it.in_pixel = px;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    n_reqs++;
  endtask

  // Stops offering requests until every owed result has come back.
  task automatic wait_results(int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned m,
                           logic [63:0] wa, logic [63:0] wb, logic [63:0] wc,
                           logic [7:0] wd);
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
    write_reg(RegMaskSize, m);
    write_reg(RegWeightsA, wa);
    write_reg(RegWeightsB, wb);
    write_reg(RegWeightsC, wc);
    write_reg(RegWeightsD, {56'd0, wd});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_weights();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(3))
        0: v[8*i +: 8] = 8'd0;
        1: v[8*i +: 8] = 8'hff;
        default: v[8*i +: 8] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  // Sends a frame of pixels, or a part of it, with scattered drains. A full frame
  // ends with drains until every owed result of the frame has been issued.
  task automatic pixel_frame(bit partial, bit extremes, bit pause_mid);
    int unsigned total, n;
    logic [PixW-1:0] px;
    total = sb.frame_total();
    n = partial ? $urandom_range(1, (total < 40) ? total : 40) : total;
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_results(0);
      if ($urandom_range(9) == 0) send_req(CmdDrain, $urandom);
      px = extremes ? ($urandom_range(1) ? '1 : '0) : $urandom;
      send_req(CmdPixel, px);
    end
    if (!partial) begin
      // A pixel beyond the frame is dropped while results are still owed.
      if (sb.recv_cnt == total && $urandom_range(3) == 0) send_req(CmdPixel, $urandom);
      while (sb.recv_cnt != 0) send_req(CmdDrain, $urandom);
    end
  endtask

  task automatic set_mode(int unsigned mode);
    case (mode % 4)
      0: begin in_idle_pct = 0; stall_pct = 0; end
      1: begin in_idle_pct = 63; stall_pct = 0; end
      2: begin in_idle_pct = 0; stall_pct = 63; end
      default: begin in_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  initial begin
    int unsigned phase;
    int unsigned w, h, m;
    logic [63:0] wa, wb, wc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drain with nothing eligible, then a 3x3 frame of black and white pixels.
    configure(3, 3, 3, 64'h0101010101010101, 64'h0101010101010101, '0, 8'd0);
    send_req(CmdDrain, '1);
    pixel_frame(1'b0, 1'b1, 1'b0);
    wait_results(SettleCycles);

    // Zero geometry clamps to a single pixel; all weights zero.
    configure(0, 0, 0, '0, '0, '0, 8'd0);
    send_req(CmdPixel, 32'h80ffffff);
    send_req(CmdPixel, '1);
    wait_results(SettleCycles);

    // Oversized width and an even mask size.
    set_mode(3);
    configure(2047, 1, 2, '1, 64'h00ff00ff00ff00ff, rand_weights(), 8'hff);
    pixel_frame(1'b1, 1'b1, 1'b0);
    wait_results(SettleCycles);

    // Oversized height with a mask size beyond the largest one.
    configure(1, 2047, 7, '1, '1, '1, 8'hff);
    pixel_frame(1'b1, 1'b0, 1'b0);
    wait_results(SettleCycles);

    phase = 0;
    while (n_reqs < 430) begin
      set_mode(phase);
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      m = $urandom_range(0, 7);
      wa = rand_weights();
      wb = rand_weights();
      wc = rand_weights();
      if ($urandom_range(9) == 0) begin
        wa = '0;
        wb = '0;
        wc = '0;
      end
      configure(w, h, m, wa, wb, wc, 8'($urandom));
      if (phase == 3) begin
        hold_asks++;
        pixel_frame(1'b0, 1'b0, 1'b0);
      end else if (phase == 5) begin
        pixel_frame(1'b0, 1'b0, 1'b1);
      end else begin
        pixel_frame($urandom_range(5) == 0, 1'b0, 1'b0);
      end
      wait_results(SettleCycles);
      phase++;
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("** weighted_mask_blur: PASSED **");
    end else begin
      $display("** weighted_mask_blur: FAILED **");
    end
    $finish;
  end

endmodule
